FILE: rtl/tlob_pkg.sv
// shared types for the two-layer order blend compositor
// input pixel pair and result pixel structs; no dependencies
package tlob_pkg;

    typedef struct packed {
        logic [7:0] first_red;
        logic [7:0] first_green;
        logic [7:0] first_blue;
        logic [7:0] first_alpha;
        logic [7:0] second_red;
        logic [7:0] second_green;
        logic [7:0] second_blue;
        logic [7:0] second_alpha;
        logic [7:0] order_weight;
    } t_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } t_result;

    localparam int unsigned NUM_BYTES = 9;

endpackage

FILE: rtl/tlob_front.sv
// front end: byte normalisation, over weights, over numerators and alphas
// three register stages; uses tlob_pkg
module tlob_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  tlob_pkg::t_item                       i_item,
    output logic                                  o_valid,
    output logic [1:0][2:0][2*FRAC_BITS+2:0]      o_num,
    output logic [1:0][FRAC_BITS:0]               o_den,
    output logic                                  o_zero,
    output logic [FRAC_BITS:0]                    o_w
);
    localparam int QW = FRAC_BITS + 1;
    localparam int NW = 2 * FRAC_BITS + 3;
    localparam int XW = FRAC_BITS + 8;
    localparam int MW = FRAC_BITS + 9;
    localparam int SH = FRAC_BITS + 16;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + 64'd254) / 64'd255);
    localparam logic [QW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [7:0]                 w_byte [tlob_pkg::NUM_BYTES];
    logic [QW-1:0]              n_norm [tlob_pkg::NUM_BYTES];
    logic [QW-1:0]              r_norm [tlob_pkg::NUM_BYTES];
    logic [QW-1:0]              r_val2 [tlob_pkg::NUM_BYTES];
    logic [1:0][QW-1:0]         n_wy, r_wy;
    logic [1:0][2:0][NW-1:0]    n_num;
    logic [1:0][QW-1:0]         n_den;
    logic                       r_v1, r_v2, r_v3;

    assign w_byte[0] = i_item.first_red;
    assign w_byte[1] = i_item.first_green;
    assign w_byte[2] = i_item.first_blue;
    assign w_byte[3] = i_item.first_alpha;
    assign w_byte[4] = i_item.second_red;
    assign w_byte[5] = i_item.second_green;
    assign w_byte[6] = i_item.second_blue;
    assign w_byte[7] = i_item.second_alpha;
    assign w_byte[8] = i_item.order_weight;

    // v/255 with rounding offset, by reciprocal multiply
    always_comb begin
        logic [XW-1:0]    x;
        logic [XW+MW-1:0] p;
        for (int k = 0; k < tlob_pkg::NUM_BYTES; k++) begin
            x = {w_byte[k], {FRAC_BITS{1'b0}}} + XW'(127);
            p = (XW+MW)'(x) * (XW+MW)'(RECIP);
            n_norm[k] = p[SH +: QW];
        end
    end

    // background weight of each over
    always_comb begin
        logic [2*QW-1:0] p0, p1;
        p0 = (2*QW)'(ONE - r_norm[3]) * (2*QW)'(r_norm[7]);
        p1 = (2*QW)'(ONE - r_norm[7]) * (2*QW)'(r_norm[3]);
        n_wy[0] = p0[FRAC_BITS +: QW];
        n_wy[1] = p1[FRAC_BITS +: QW];
    end

    // numerators and composite alphas
    always_comb begin
        logic [QW:0] s0, s1;
        for (int c = 0; c < 3; c++) begin
            n_num[0][c] = NW'((2*QW)'(r_val2[c]) * (2*QW)'(r_val2[3]))
                        + NW'((2*QW)'(r_val2[4+c]) * (2*QW)'(r_wy[0]));
            n_num[1][c] = NW'((2*QW)'(r_val2[4+c]) * (2*QW)'(r_val2[7]))
                        + NW'((2*QW)'(r_val2[c]) * (2*QW)'(r_wy[1]));
        end
        s0 = {1'b0, r_val2[3]} + {1'b0, r_wy[0]};
        s1 = {1'b0, r_val2[7]} + {1'b0, r_wy[1]};
        n_den[0] = s0[QW-1:0];
        n_den[1] = s1[QW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_norm <= n_norm;
        r_val2 <= r_norm;
        r_wy   <= n_wy;
        o_num  <= n_num;
        o_den  <= n_den;
        o_zero <= (r_val2[3] == '0) && (r_val2[7] == '0);
        o_w    <= r_val2[8];
    end

    assign o_valid = r_v3;

endmodule

FILE: rtl/tlob_div.sv
// pipelined restoring divider, one quotient bit per stage
// quotient must fit FRAC_BITS+1 bits; no package dependency
module tlob_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic [2*FRAC_BITS+2:0] i_num,
    input  logic [FRAC_BITS:0]     i_den,
    output logic [FRAC_BITS:0]     o_quo
);
    localparam int QW = FRAC_BITS + 1;
    localparam int NW = 2 * FRAC_BITS + 3;

    logic [QW-1:0] r_rem [QW];
    logic [QW-1:0] r_low [QW];
    logic [QW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [QW-1:0] w_rem, w_low, w_den, w_quo;
        logic [QW+1:0] w_trial;

        if (k == 0) begin : g_first
            // numerator top bit is always clear; the next QW bits sit below the divisor
            assign w_rem = i_num[NW-2 -: QW];
            assign w_low = i_num[QW-1:0];
            assign w_den = i_den;
            assign w_quo = '0;
        end else begin : g_next
            assign w_rem = r_rem[k-1];
            assign w_low = r_low[k-1];
            assign w_den = r_den[k-1];
            assign w_quo = r_quo[k-1];
        end

        assign w_trial = {1'b0, w_rem, w_low[QW-1]} - {2'b00, w_den};

        always_ff @(posedge i_clk) begin
            if (!w_trial[QW+1]) begin
                r_rem[k] <= w_trial[QW-1:0];
            end else begin
                r_rem[k] <= {w_rem[QW-2:0], w_low[QW-1]};
            end
            r_quo[k] <= {w_quo[QW-2:0], ~w_trial[QW+1]};
            r_low[k] <= {w_low[QW-2:0], 1'b0};
            r_den[k] <= w_den;
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

FILE: rtl/tlob_blend.sv
// order blend of the two composites and 8-bit quantisation
// single register stage driving the result port; uses tlob_pkg
module tlob_blend #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic                    i_zero,
    input  logic [FRAC_BITS:0]      i_w,
    input  logic [3:0][FRAC_BITS:0] i_ab,
    input  logic [3:0][FRAC_BITS:0] i_ba,
    output logic                    o_strobe,
    output tlob_pkg::t_result       o_result
);
    localparam int QW = FRAC_BITS + 1;
    localparam logic [QW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [3:0][7:0] n_q;
    logic            r_strobe;

    always_comb begin
        logic [2*QW:0]   s;
        logic [QW-1:0]   ab, ba, cq;
        for (int c = 0; c < 4; c++) begin
            ab = i_zero ? '0 : i_ab[c];
            ba = i_zero ? '0 : i_ba[c];
            s  = (2*QW+1)'((2*QW)'(ab) * (2*QW)'(ONE - i_w))
               + (2*QW+1)'((2*QW)'(ba) * (2*QW)'(i_w));
            cq = s[FRAC_BITS +: QW];
            // full scale saturates
            n_q[c] = cq[FRAC_BITS] ? 8'hFF : cq[FRAC_BITS-1 -: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result.out_red   <= n_q[0];
        o_result.out_green <= n_q[1];
        o_result.out_blue  <= n_q[2];
        o_result.out_alpha <= n_q[3];
    end

    assign o_strobe = r_strobe;

endmodule

FILE: rtl/two_layer_order_blend_composite.sv
// top level of the two-layer order blend compositor
// uses tlob_pkg, tlob_front, tlob_div and tlob_blend
//
// one pixel pair per clock: a transfer is taken whenever start is high, and busy
// never rises, so a new pixel may follow in every cycle. each result appears on
// o_result for one cycle with o_strobe high, in transfer order; it must be
// captured then, as the block cannot be held. the result passes through three
// front stages, the composite colour divide, which resolves one quotient bit
// per stage over FRAC_BITS+1 stages, and the output register.
// layer A over B and B over A are formed in straight alpha, then blended
// toward B over A by order_weight/255 and quantised to 8 bits.
module two_layer_order_blend_composite #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  tlob_pkg::t_item   i_item,
    output logic              busy,
    output logic              o_strobe,
    output tlob_pkg::t_result o_result
);
    localparam int QW = FRAC_BITS + 1;
    localparam int NW = 2 * FRAC_BITS + 3;

    // front end outputs
    logic                      w_f_valid;
    logic [1:0][2:0][NW-1:0]   w_num;
    logic [1:0][QW-1:0]        w_den;
    logic                      w_zero;
    logic [QW-1:0]             w_w;

    // quotients: [0] is A over B, [1] is B over A
    logic [1:0][2:0][QW-1:0]   w_quo;

    // sideband riding alongside the divider stages
    logic                      r_sb_v    [QW];
    logic                      r_sb_zero [QW];
    logic [QW-1:0]             r_sb_w    [QW];
    logic [1:0][QW-1:0]        r_sb_den  [QW];

    logic [3:0][QW-1:0]        w_ab, w_ba;

    // never stalls
    assign busy = 1'b0;

    tlob_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_item  (i_item),
        .o_valid (w_f_valid),
        .o_num   (w_num),
        .o_den   (w_den),
        .o_zero  (w_zero),
        .o_w     (w_w)
    );

    // six dividers, one per composite colour channel
    for (genvar d = 0; d < 2; d++) begin : g_comp
        for (genvar c = 0; c < 3; c++) begin : g_chan
            tlob_div #(
                .FRAC_BITS(FRAC_BITS)
            ) u_div (
                .i_clk (i_clk),
                .i_num (w_num[d][c]),
                .i_den (w_den[d]),
                .o_quo (w_quo[d][c])
            );
        end
    end

    // valid delay line, cleared on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) begin
                r_sb_v[k] <= 1'b0;
            end
        end else begin
            r_sb_v[0] <= w_f_valid;
            for (int k = 1; k < QW; k++) begin
                r_sb_v[k] <= r_sb_v[k-1];
            end
        end
    end

    // payload delay line matching the divider depth
    always_ff @(posedge i_clk) begin
        r_sb_zero[0] <= w_zero;
        r_sb_w[0]    <= w_w;
        r_sb_den[0]  <= w_den;
        for (int k = 1; k < QW; k++) begin
            r_sb_zero[k] <= r_sb_zero[k-1];
            r_sb_w[k]    <= r_sb_w[k-1];
            r_sb_den[k]  <= r_sb_den[k-1];
        end
    end

    // colours from the dividers, alpha from the delayed composite alpha
    assign w_ab = {r_sb_den[QW-1][0], w_quo[0][2], w_quo[0][1], w_quo[0][0]};
    assign w_ba = {r_sb_den[QW-1][1], w_quo[1][2], w_quo[1][1], w_quo[1][0]};

    tlob_blend #(
        .FRAC_BITS(FRAC_BITS)
    ) u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_sb_v[QW-1]),
        .i_zero   (r_sb_zero[QW-1]),
        .i_w      (r_sb_w[QW-1]),
        .i_ab     (w_ab),
        .i_ba     (w_ba),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

FILE: rtl/tlob_checker.sv
// port-level checks for the compositor, bound to the top level
// uses tlob_pkg; attaches through the bind below
module tlob_assert #(
    parameter int FRAC_BITS = 16
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input tlob_pkg::t_item   i_item,
    input logic              busy,
    input logic              o_strobe,
    input tlob_pkg::t_result o_result
);
    localparam int LAT = FRAC_BITS + 5;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_strobe_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LAT))
        else $error("result without a matching transfer");

    a_both_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_item.first_alpha == 8'd0 && i_item.second_alpha == 8'd0)
        |-> ##LAT (o_strobe && o_result.out_red == 8'd0
            && o_result.out_green == 8'd0 && o_result.out_blue == 8'd0
            && o_result.out_alpha == 8'd0))
        else $error("clear pair did not give a zero pixel");

    a_opaque_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_item.first_alpha == 8'hFF && i_item.order_weight == 8'd0)
        |-> ##LAT (o_strobe && o_result.out_alpha == 8'hFF))
        else $error("opaque front layer lost alpha");

endmodule

bind two_layer_order_blend_composite tlob_assert #(
    .FRAC_BITS(FRAC_BITS)
) u_tlob_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_item   (i_item),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

FILE: bench/tlob_checker.sv
// result checker for the two-layer order blend compositor
// predicts each pixel in Q1.16 and compares with o_result; uses tlob_pkg
`timescale 1ns / 100ps

module tlob_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  tlob_pkg::t_item   i_item,
    input  logic              o_strobe,
    input  tlob_pkg::t_result o_result,
    output int                o_fail_count,
    output int                o_pending
);
    localparam longint unsigned ONE = 64'd1 << FRAC_BITS;

    typedef struct {
        longint unsigned r, g, b, a;
    } t_qpix;

    tlob_pkg::t_result pixel_queue[$];
    int                fails = 0;

    assign o_fail_count = fails;

    function automatic longint unsigned to_unit(logic [7:0] v);
        return (longint'(v) * ONE + 127) / 255;
    endfunction

    function automatic t_qpix layer_over(t_qpix x, t_qpix y);
        t_qpix r;
        longint unsigned wy, al;
        r = '{0, 0, 0, 0};
        if (x.a + y.a == 0) return r;
        wy = ((ONE - x.a) * y.a) >> FRAC_BITS;
        al = x.a + wy;
        if (al == 0) return r;
        r.r = (x.r * x.a + y.r * wy) / al;
        r.g = (x.g * x.a + y.g * wy) / al;
        r.b = (x.b * x.a + y.b * wy) / al;
        r.a = al;
        return r;
    endfunction

    function automatic logic [7:0] mix_quant(longint unsigned ab, longint unsigned ba,
                                             longint unsigned w);
        longint unsigned c, q;
        c = (ab * (ONE - w) + ba * w) >> FRAC_BITS;
        q = c >> (FRAC_BITS - 8);
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic tlob_pkg::t_result composite_pixel(tlob_pkg::t_item it);
        t_qpix             pa, pb, ab, ba;
        longint unsigned   w;
        tlob_pkg::t_result res;
        pa = '{to_unit(it.first_red), to_unit(it.first_green),
               to_unit(it.first_blue), to_unit(it.first_alpha)};
        pb = '{to_unit(it.second_red), to_unit(it.second_green),
               to_unit(it.second_blue), to_unit(it.second_alpha)};
        w  = to_unit(it.order_weight);
        ab = layer_over(pa, pb);
        ba = layer_over(pb, pa);
        res.out_red   = mix_quant(ab.r, ba.r, w);
        res.out_green = mix_quant(ab.g, ba.g, w);
        res.out_blue  = mix_quant(ab.b, ba.b, w);
        res.out_alpha = mix_quant(ab.a, ba.a, w);
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fails++;
    endtask

    always @(posedge i_clk) begin
        tlob_pkg::t_result want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (pixel_queue.size() == 0) begin
                    report_mismatch("unexpected result", int'(o_result), 0);
                end else begin
                    want = pixel_queue.pop_front();
                    if (o_result.out_red != want.out_red)
                        report_mismatch("red", int'(o_result.out_red),
                                        int'(want.out_red));
                    if (o_result.out_green != want.out_green)
                        report_mismatch("green", int'(o_result.out_green),
                                        int'(want.out_green));
                    if (o_result.out_blue != want.out_blue)
                        report_mismatch("blue", int'(o_result.out_blue),
                                        int'(want.out_blue));
                    if (o_result.out_alpha != want.out_alpha)
                        report_mismatch("alpha", int'(o_result.out_alpha),
                                        int'(want.out_alpha));
                end
            end
            // queue after popping, so a result is only matched against earlier transfers
            if (start && !busy)
                pixel_queue = {pixel_queue, composite_pixel(i_item)};
        end
        o_pending = pixel_queue.size();
    end

endmodule

FILE: bench/tb.sv
// testbench top for the two-layer order blend compositor
// drives pixel transfers into dut; checking lives in tlob_checker (tlob_pkg)
`timescale 1ns / 100ps

module tb;
    localparam int FRAC_BITS  = 16;
    localparam int LATENCY    = FRAC_BITS + 5;
    localparam int NUM_RANDOM = 700;
    // longest quiet stretch: largest sender gap plus pipeline latency, with margin
    localparam int STALL_LIMIT = 2000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    tlob_pkg::t_item   i_item = '0;
    logic              busy;
    logic              o_strobe;
    tlob_pkg::t_result o_result;
    int                fail_count;
    int                pending;
    int                idle_cycles = 0;
    int                sent = 0;
    int                strobes = 0;

    always #10 i_clk = ~i_clk;

    two_layer_order_blend_composite #(.FRAC_BITS(FRAC_BITS)) dut (
        .i_clk, .i_rst_n, .start, .i_item, .busy, .o_strobe, .o_result
    );

    tlob_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_item, .o_strobe, .o_result,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // watchdog: counts cycles with neither an input transfer nor a result
    always @(posedge i_clk) begin
        if (o_strobe) strobes++;
        if ((start && !busy) || o_strobe || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog expired with %0d pending", pending);
            $display("tb failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one transfer: hold start until accepted, optional gap afterwards
    task automatic push_pixel(tlob_pkg::t_item it, int gap);
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic tlob_pkg::t_item random_pixel();
        tlob_pkg::t_item it;
        it = 72'({$urandom, $urandom, $urandom});
        // bias alphas toward extremes so zero and full coverage is common
        case ($urandom_range(0, 5))
            0: it.first_alpha  = 8'd0;
            1: it.second_alpha = 8'd0;
            2: it.first_alpha  = 8'd255;
            3: it.second_alpha = 8'd255;
            default: ;
        endcase
        if ($urandom_range(0, 9) == 0)
            it.order_weight = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        return it;
    endfunction

    initial begin
        tlob_pkg::t_item it;
        int              gap;
        int              burst;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes of every field and the special cases
        push_pixel('0, 0);                                   // both alphas zero
        push_pixel('1, 0);                                   // all full scale
        push_pixel('{8'd255, 8'd0, 8'd128, 8'd0, 8'd10, 8'd20, 8'd30, 8'd0, 8'd200}, 1);
        push_pixel('{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0}, 0);
        push_pixel('{8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255}, 0);
        push_pixel('{8'd200, 8'd100, 8'd50, 8'd255, 8'd7, 8'd9, 8'd11, 8'd0, 8'd128}, 3);
        push_pixel('{8'd200, 8'd100, 8'd50, 8'd0, 8'd7, 8'd9, 8'd11, 8'd255, 8'd128}, 0);
        push_pixel('{8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1}, 0);
        push_pixel('{8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
                     8'd254}, 0);
        push_pixel('{8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA}, 2);
        push_pixel('{8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55}, 0);
        push_pixel('{8'd255, 8'd255, 8'd255, 8'd128, 8'd255, 8'd255, 8'd255, 8'd128,
                     8'd255}, 0);

        // random: pixels sent back to back alternate with pixels followed by a random gap
        burst = 0;
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (burst == 0) burst = $urandom_range(1, 40);
            burst--;
            it  = random_pixel();
            gap = (burst % 2) ? 0 : $urandom_range(0, 13);
            push_pixel(it, gap);
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);

        $display("sent %0d pixel pairs (directed extremes and random), %0d results seen",
                 sent, strobes);
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
